/* hw/rtl/pcg32_random_generator_defines.svh */
// Assertion macros for the PCG32 generator.
// No dependencies; included by the top level where it asserts.
`ifndef PCG32_RANDOM_GENERATOR_DEFINES_SVH
`define PCG32_RANDOM_GENERATOR_DEFINES_SVH

`ifndef SYNTH
`define PCG_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pcg32 assertion failed");
`define PCG_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("pcg32 reset assertion failed");
`else
`define PCG_ASSERT(label, prop)
`define PCG_ASSERT_RST(label, prop)
`endif

`endif

/* hw/rtl/pcg_pkg.sv */
// Shared types, constants and the output permutation of the PCG32 generator.
// No dependencies; used by pcg_front, pcg_back and the top level.
package pcg_pkg;

    localparam int unsigned PCG_WIDTH   = 32;
    localparam int unsigned PCG_CNT_W   = $clog2(PCG_WIDTH);
    localparam int unsigned PCG_Q_DEPTH = 2;

    localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;
    localparam logic [63:0] PCG_INC  = 64'd1442695040888963407;
    // seed 0 plus increment, advanced once
    localparam logic [63:0] PCG_STATE_RESET = PCG_INC * PCG_MULT + PCG_INC;

    typedef enum logic [1:0] {
        ACT_RAW    = 2'd0,
        ACT_RANGE  = 2'd1,
        ACT_RESEED = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [31:0] lo;
        logic [31:0] span;
        logic        span_zero;
    } t_cmd;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_front_status;

    typedef struct packed {
        logic busy;
        logic dividing;
    } t_back_status;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL0,
        BK_MUL1,
        BK_MUL2,
        BK_DIV,
        BK_DONE
    } t_back_state;

    // XSH-RR: xorshift high bits, rotate by top five bits of the state
    function automatic logic [31:0] pcg_output(input logic [63:0] state);
        logic [63:0] x;
        logic [31:0] xs;
        logic [63:0] dbl;
        x   = state ^ (state >> 18);
        xs  = x[58:27];
        dbl = {xs, xs} >> state[63:59];
        return dbl[31:0];
    endfunction

endpackage

/* hw/rtl/pcg_front.sv */
// Front end: accepts input words, decodes the action, precomputes the span
// and buffers decoded commands in a short queue. Depends on pcg_pkg.
module pcg_front #(
    parameter int unsigned DEPTH = pcg_pkg::PCG_Q_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_action,
    input  logic signed [31:0]    i_range_low,
    input  logic signed [31:0]    i_range_high,
    output pcg_pkg::t_cmd         o_cmd,
    input  logic                  i_cmd_pop,
    output pcg_pkg::t_front_status o_status
);
    import pcg_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LVL_W = $clog2(DEPTH + 1);

    t_cmd             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [LVL_W-1:0] r_level, n_level;
    t_cmd             dec;
    logic             push;
    logic             pop;

    always_comb begin
        unique case (i_action)
            2'd0:    dec.action = ACT_RAW;
            2'd1:    dec.action = ACT_RANGE;
            2'd2:    dec.action = ACT_RESEED;
            default: dec.action = ACT_NONE;
        endcase
        dec.lo        = $unsigned(i_range_low);
        dec.span      = $unsigned(i_range_high) - $unsigned(i_range_low);
        dec.span_zero = (dec.span == '0);
    end

    assign o_in_ready       = (r_level != LVL_W'(DEPTH));
    assign push             = i_in_valid && o_in_ready;
    assign pop              = i_cmd_pop && (r_level != '0);
    assign o_cmd            = r_slot[r_rd_ptr];
    assign o_status.not_empty = (r_level != '0);
    assign o_status.full      = !o_in_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_level  = r_level;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_level = r_level + 1'b1;
        end else if (pop && !push) begin
            n_level = r_level - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_level  <= n_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= dec;
        end
    end

endmodule

/* hw/rtl/pcg_back.sv */
// Back end: LCG step on a shared 32x32 multiplier, radix-2 remainder unit
// for ranged draws, and the output register. Depends on pcg_pkg.
module pcg_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pcg_pkg::t_cmd        i_cmd,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_pop,
    input  logic [31:0]          i_seed,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [31:0]          o_value,
    output logic                 o_span_zero,
    output pcg_pkg::t_back_status o_status
);
    import pcg_pkg::*;

    t_back_state          r_state, n_state;
    t_action              r_action;
    logic [31:0]          r_lo;
    logic [31:0]          r_span;
    logic                 r_zero;
    logic [31:0]          r_draw;
    logic [63:0]          r_opnd;
    logic [63:0]          r_prod_lo;
    logic [31:0]          r_cross;
    logic [31:0]          r_rem;
    logic [31:0]          r_dvd;
    logic [PCG_CNT_W-1:0] r_cnt;
    logic [63:0]          r_lcg;
    logic                 r_out_valid;
    logic [31:0]          r_out_value;
    logic                 r_out_span_zero;

    logic        out_free;
    logic        out_load;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [32:0] div_t;
    logic        div_ge;
    logic [32:0] div_diff;
    logic [31:0] rem_nx;
    logic        div_last;
    logic [31:0] res_value;

    assign out_free = !r_out_valid || i_out_ready;
    assign div_last = (r_cnt == PCG_CNT_W'(PCG_WIDTH - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = (i_cmd.action == ACT_NONE) ? BK_DONE : BK_MUL0;
                end
            end
            BK_MUL0: n_state = BK_MUL1;
            BK_MUL1: n_state = BK_MUL2;
            BK_MUL2: n_state = (r_action == ACT_RANGE && !r_zero) ? BK_DIV : BK_DONE;
            BK_DIV:  n_state = div_last ? BK_DONE : BK_DIV;
            BK_DONE: n_state = out_free ? BK_IDLE : BK_DONE;
            default: n_state = BK_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_cmd_pop = 1'b0;
        out_load  = 1'b0;
        mul_a     = r_opnd[31:0];
        mul_b     = PCG_MULT[31:0];
        unique case (r_state)
            BK_IDLE: o_cmd_pop = i_cmd_valid;
            BK_MUL1: mul_a = r_opnd[63:32];
            BK_MUL2: mul_b = PCG_MULT[63:32];
            BK_DONE: out_load = out_free;
            default: ;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign div_t    = {r_rem, r_dvd[31]};
    assign div_diff = div_t - {1'b0, r_span};
    assign div_ge   = !div_diff[32];
    assign rem_nx   = div_ge ? div_diff[31:0] : div_t[31:0];

    always_comb begin
        unique case (r_action)
            ACT_RAW:   res_value = r_draw;
            ACT_RANGE: res_value = r_zero ? '0 : r_lo + r_rem;
            default:   res_value = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_lcg       <= PCG_STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_MUL2) begin
                r_lcg <= r_prod_lo + {r_cross + mul_p[31:0], 32'd0} + PCG_INC;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            BK_IDLE: begin
                r_action <= i_cmd.action;
                r_lo     <= i_cmd.lo;
                r_span   <= i_cmd.span;
                r_zero   <= i_cmd.span_zero;
                r_draw   <= pcg_output(r_lcg);
                r_dvd    <= pcg_output(r_lcg);
                r_rem    <= '0;
                r_cnt    <= '0;
                r_opnd   <= (i_cmd.action == ACT_RESEED) ? ({32'd0, i_seed} + PCG_INC)
                                                         : r_lcg;
            end
            BK_MUL0: r_prod_lo <= mul_p;
            BK_MUL1: r_cross   <= mul_p[31:0];
            BK_DIV: begin
                r_rem <= rem_nx;
                r_dvd <= {r_dvd[30:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_value     <= res_value;
            r_out_span_zero <= (r_action == ACT_RANGE) && r_zero;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_value           = r_out_value;
    assign o_span_zero       = r_out_span_zero;
    assign o_status.busy     = (r_state != BK_IDLE);
    assign o_status.dividing = (r_state == BK_DIV);

endmodule

/* hw/rtl/pcg32_random_generator.sv */
// PCG32 XSH-RR random generator, top level.
// Input channel (i_in_valid / o_in_ready) carries one word per action:
// raw draw, ranged draw over [range_low, range_high), or reseed from the
// seed register. Output channel (o_out_valid / i_out_ready) returns one
// word per input word, in order: value and the zero-span flag.
// The seed register is written through i_cfg_wr_en / i_cfg_wr_data.
// A raw draw, a reseed or a zero-span ranged draw passes the states BK_MUL0,
// BK_MUL1, BK_MUL2 and BK_DONE; any other ranged draw runs BK_DIV between
// BK_MUL2 and BK_DONE; an unused action code goes straight to BK_DONE. The
// LCG step uses one 32x32 multiplier over BK_MUL0, BK_MUL1 and BK_MUL2; a
// ranged draw with nonzero span adds a radix-2 remainder unit in BK_DIV. One
// word is in the back end at a time, so it takes no new word until the last
// result is loaded into the output register.
// A decoded-command queue of Q_DEPTH words sits in front of the back end.
// Reset (synchronous, active low) clears the seed to 0 and loads the
// state as if reseeded with 0; the output register comes up empty.
// When the receiver stalls, the result holds in the output register; the
// queue keeps taking words until it is full, then o_in_ready drops.
// Depends on pcg_pkg, pcg_front, pcg_back and the defines header.
`include "pcg32_random_generator_defines.svh"

module pcg32_random_generator #(
    parameter int unsigned Q_DEPTH = pcg_pkg::PCG_Q_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [31:0]        i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_range_low,
    input  logic signed [31:0] i_range_high,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [31:0]        o_value,
    output logic               o_span_zero
);
    import pcg_pkg::*;

    logic [31:0]   r_seed_value;
    t_cmd          cmd;
    logic          cmd_pop;
    t_front_status front_status;
    t_back_status  back_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_value <= '0;
        end else if (i_cfg_wr_en) begin
            r_seed_value <= i_cfg_wr_data;
        end
    end

    pcg_front #(
        .DEPTH (Q_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_range_low  (i_range_low),
        .i_range_high (i_range_high),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop),
        .o_status     (front_status)
    );

    pcg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (front_status.not_empty),
        .o_cmd_pop   (cmd_pop),
        .i_seed      (r_seed_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_value     (o_value),
        .o_span_zero (o_span_zero),
        .o_status    (back_status)
    );

    `PCG_ASSERT_RST(a_out_empty_after_reset, !i_rst_n |=> !o_out_valid)
    `PCG_ASSERT(a_queued_word_picked_up,
        front_status.not_empty && !back_status.busy |=> back_status.busy)
    `PCG_ASSERT(a_result_from_busy_back, $rose(o_out_valid) |-> $past(back_status.busy))
    `PCG_ASSERT(a_full_stalls_input, front_status.full |-> !o_in_ready)
    `PCG_ASSERT(a_divider_only_when_busy, back_status.dividing |-> back_status.busy)

endmodule

/* test/pcg32_random_generator_tb.sv */
// Self-checking testbench for pcg32_random_generator: directed corners, then random traffic
// with random stalls on both handshakes. Every output word is checked against an internal model.
// Depends on pcg_pkg and the pcg32_random_generator RTL.
module pcg32_random_generator_tb;
    import pcg_pkg::*;

    localparam logic [63:0] LCG_MULT = 64'd6364136223846793005;
    localparam logic [63:0] LCG_INC  = 64'd1442695040888963407;
    localparam int unsigned RANDOM_WORDS = 600;

    typedef struct packed {
        logic [31:0] value;
        logic        span_zero;
    } t_draw_result;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic [31:0]        i_cfg_wr_data = '0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_action      = '0;
    logic signed [31:0] i_range_low   = '0;
    logic signed [31:0] i_range_high  = '0;
    logic               o_out_valid;
    logic               i_out_ready   = 1'b0;
    logic [31:0]        o_value;
    logic               o_span_zero;

    logic [63:0]  model_lcg;
    logic [31:0]  model_seed;
    t_draw_result pending_draws[$];
    int unsigned  mismatches = 0;
    bit           in_quiet   = 1'b0;
    bit           out_quiet  = 1'b0;

    pcg32_random_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_range_low   (i_range_low),
        .i_range_high  (i_range_high),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_value       (o_value),
        .o_span_zero   (o_span_zero)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------- model ----------------
    function automatic logic [31:0] xsh_rr(input logic [63:0] s);
        logic [63:0] x;
        logic [31:0] w;
        logic [4:0]  r;
        x = s ^ (s >> 18);
        w = x[58:27];
        r = s[63:59];
        return (w >> r) | (w << (32 - r));
    endfunction

    function automatic logic [31:0] lcg_draw();
        logic [63:0] old;
        old       = model_lcg;
        model_lcg = old * LCG_MULT + LCG_INC;
        return xsh_rr(old);
    endfunction

    function automatic void lcg_reseed();
        logic [31:0] unused;
        model_lcg = {32'd0, model_seed} + LCG_INC;
        unused    = lcg_draw();
    endfunction

    function automatic t_draw_result pcg_predict(input t_action act, input logic [31:0] lo,
                                                 input logic [31:0] hi);
        t_draw_result r;
        logic [31:0]  span;
        logic [31:0]  d;
        r    = '0;
        span = hi - lo;
        case (act)
            ACT_RAW: r.value = lcg_draw();
            ACT_RANGE: begin
                d = lcg_draw();
                if (span == 32'd0) r.span_zero = 1'b1;
                else r.value = lo + d % span;
            end
            ACT_RESEED: lcg_reseed();
            default: ;
        endcase
        return r;
    endfunction

    // ---------------- handshakes ----------------
    function automatic int unsigned pick_wait(input bit quiet);
        return quiet ? 0 : $urandom_range(0, 17);
    endfunction

    task automatic send_word(input t_action act, input logic [31:0] lo, input logic [31:0] hi);
        int unsigned gap;
        gap = pick_wait(in_quiet);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_range_low  <= lo;
        i_range_high <= hi;
        do @(posedge i_clk); while (!o_in_ready);
        pending_draws.push_back(pcg_predict(act, lo, hi));
    endtask

    task automatic drain_words();
        i_in_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_seed(input logic [31:0] seed);
        drain_words();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= seed;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        model_seed = seed;
    endtask

    initial begin
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = pick_wait(out_quiet);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic note_mismatch(input string what, input t_draw_result exp_w,
                                 input t_draw_result got_w);
        if (mismatches < 10)
            $display("%s: expected value %h span_zero %b, got value %h span_zero %b",
                     what, exp_w.value, exp_w.span_zero, got_w.value, got_w.span_zero);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_results
        t_draw_result exp_w;
        t_draw_result got_w;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_w.value     = o_value;
            got_w.span_zero = o_span_zero;
            if (pending_draws.size() == 0) begin
                note_mismatch("word with nothing pending", '0, got_w);
            end else begin
                exp_w = pending_draws.pop_front();
                if (got_w.value !== exp_w.value || got_w.span_zero !== exp_w.span_zero)
                    note_mismatch("word mismatch", exp_w, got_w);
            end
        end
    end

    // ---------------- tests ----------------
    function automatic logic [31:0] pick_bound();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return $urandom_range(0, 20);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_reset_state();
        repeat (3) send_word(ACT_RAW, $urandom, $urandom);
        drain_words();
    endtask

    task automatic test_range_corners();
        send_word(ACT_RANGE, 32'h8000_0000, 32'h7fff_ffff);
        send_word(ACT_RANGE, 32'h7fff_ffff, 32'h8000_0000);
        send_word(ACT_RANGE, 32'd5, 32'd5);
        send_word(ACT_RANGE, 32'h8000_0000, 32'h8000_0000);
        send_word(ACT_RANGE, 32'd0, 32'd1);
        send_word(ACT_RANGE, 32'd0, 32'hffff_ffff);
        send_word(ACT_RANGE, 32'd0, 32'd10);
        send_word(ACT_RANGE, 32'hffff_ffff, 32'd0);
        send_word(ACT_RANGE, 32'd10, 32'd0);
        send_word(ACT_NONE, 32'hffff_ffff, 32'hffff_ffff);
        send_word(ACT_RAW, 32'hffff_ffff, 32'd0);
        send_word(ACT_RESEED, 32'd0, 32'hffff_ffff);
        send_word(ACT_RAW, 32'd0, 32'd0);
        drain_words();
    endtask

    task automatic test_seed_register();
        logic [31:0] seeds[4];
        seeds = '{32'hffff_ffff, 32'h8000_0000, 32'd1, 32'd0};
        foreach (seeds[k]) begin
            load_seed(seeds[k]);
            send_word(ACT_RESEED, $urandom, $urandom);
            send_word(ACT_RAW, $urandom, $urandom);
        end
        // a seed write alone leaves the state alone
        load_seed(32'h1234_5678);
        send_word(ACT_RAW, $urandom, $urandom);
        drain_words();
    endtask

    task automatic test_random_traffic();
        int unsigned pick;
        logic [31:0] lo;
        logic [31:0] hi;
        for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 100 == 0) load_seed(pick_bound());
            if (n % 40 == 0) begin
                in_quiet  = ($urandom_range(0, 3) == 0);
                out_quiet = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            lo   = pick_bound();
            case ($urandom_range(0, 7))
                0: hi = lo;
                1: hi = lo + $urandom_range(1, 16);
                default: hi = pick_bound();
            endcase
            if (pick < 35) send_word(ACT_RAW, lo, hi);
            else if (pick < 82) send_word(ACT_RANGE, lo, hi);
            else if (pick < 94) send_word(ACT_RESEED, lo, hi);
            else send_word(ACT_NONE, lo, hi);
        end
        drain_words();
        in_quiet  = 1'b0;
        out_quiet = 1'b0;
    endtask

    initial begin
        model_seed = 32'd0;
        lcg_reseed();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_range_corners();
        test_seed_register();
        test_random_traffic();
        repeat (60) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/pcg_pkg.sv
hw/rtl/pcg_front.sv
hw/rtl/pcg_back.sv
hw/rtl/pcg32_random_generator.sv
test/pcg32_random_generator_tb.sv
